/* hdl/etcd_pkg.sv */
// Constants and helpers shared by the epoch to calendar date converter.
package etcd_pkg;

  localparam int unsigned OffsetWidth = 18;
  localparam int unsigned AddrWidth   = 3;

  localparam logic REG_ZONE_OFFSET = 1'b0;

  // Reciprocals for exact division by constants.
  // Divide by 15 for a 31-bit dividend, result is the product shifted right by 35.
  localparam logic [31:0] RECIP_15_WIDE   = 32'd2290649225;
  localparam int unsigned RECIP_15_WIDE_SH = 35;
  // Divide by 15 for a 26-bit dividend, result is the product shifted right by 30.
  localparam logic [26:0] RECIP_15_NARROW = 27'd71582789;
  localparam int unsigned RECIP_15_NARROW_SH = 30;
  // Divide by 4383 for an 18-bit dividend, result is the product shifted right by 31.
  localparam logic [18:0] RECIP_4383      = 19'd489958;
  localparam int unsigned RECIP_4383_SH   = 31;
  // Divide by 3 for an 11-bit dividend, result is the product shifted right by 13.
  localparam logic [11:0] RECIP_3         = 12'd2731;
  localparam int unsigned RECIP_3_SH      = 13;

  localparam logic [20:0] HOURS_PER_4YEARS = 21'd35064;
  localparam logic [15:0] HOURS_YEAR_1     = 16'd8760;
  localparam logic [15:0] HOURS_YEAR_2     = 16'd17520;
  localparam logic [15:0] HOURS_YEAR_3     = 16'd26304;
  localparam logic [7:0]  BASE_YEAR        = 8'd70;
  localparam logic [8:0]  LEAP_DAY_OF_YEAR = 9'd60;
  localparam logic [3:0]  MONTH_FEBRUARY   = 4'd1;
  localparam logic [4:0]  LEAP_DAY_OF_MONTH = 5'd29;

  // Days of a common year that come before the given month.
  function automatic logic [8:0] month_base(input logic [3:0] mon);
    logic [8:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

/* hdl/epoch_to_calendar_date.sv */
// Epoch seconds to calendar date and time converter, top level.
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00, less the programmed
// zone offset (clamped at zero), into second, minute, hour, day of month, month
// (0 is January) and years since 1900; every year divisible by four is a leap year.
// One timestamp enters per clock cycle while the output is not stalled, and its date
// leaves the nine-stage pipeline, which divides by 60, 60, 1461 days, single years and 24.
// A stall at the output freezes the whole pipeline and raises the input
// stall in the same cycle. The zone offset lives at byte address 0 as an 18-bit
// signed value and reads back sign-extended to 32 bits.
module epoch_to_calendar_date
  import etcd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          epoch_seconds_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [5:0]           second_of_minute_o,
  output logic [5:0]           minute_of_hour_o,
  output logic [4:0]           hour_of_day_o,
  output logic [4:0]           day_of_month_o,
  output logic [3:0]           month_index_o,
  output logic [7:0]           year_since_1900_o
);

  localparam int unsigned Stages = 9;

  logic [OffsetWidth-1:0] offset_q;
  logic [Stages-1:0]      valid_q;
  logic                   advance;

  // Stage registers
  logic [32:0] t1_q;
  logic [27:0] q2_q;
  logic [5:0]  tl2_q;
  logic [20:0] hrs3_q;
  logic [5:0]  ml3_q;
  logic [5:0]  sec3_q;
  logic [5:0]  blk4_q;
  logic [20:0] hrs4_q;
  logic [5:0]  min4_q, sec4_q;
  logic [15:0] hrem5_q;
  logic [7:0]  yb5_q;
  logic [5:0]  min5_q, sec5_q;
  logic [13:0] hy6_q;
  logic [7:0]  yr6_q;
  logic [5:0]  min6_q, sec6_q;
  logic [8:0]  dq7_q;
  logic [4:0]  hl7_q;
  logic [7:0]  yr7_q;
  logic [5:0]  min7_q, sec7_q;
  logic [8:0]  doy8_q;
  logic        ld8_q;
  logic [4:0]  hour8_q;
  logic [7:0]  yr8_q;
  logic [5:0]  min8_q, sec8_q;
  logic [5:0]  sec9_q, min9_q;
  logic [4:0]  hour9_q, day9_q;
  logic [3:0]  mon9_q;
  logic [7:0]  yr9_q;

  // Next values
  logic [33:0] local_d;
  logic [32:0] t1_d;
  logic [62:0] prod1;
  logic [52:0] prod2;
  logic [36:0] prod3;
  logic [20:0] blk_hours;
  logic [15:0] hrem_d;
  logic [1:0]  yoff_d;
  logic [15:0] ysub_d;
  logic [22:0] prod6;
  logic [8:0]  dayn;
  logic        leap7;
  logic [8:0]  doy_d;
  logic        ld_d;
  logic [3:0]  mon_d;
  logic [4:0]  day_d;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {{(32-OffsetWidth){offset_q[OffsetWidth-1]}}, offset_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ZONE_OFFSET) begin
      offset_q <= pwdata[OffsetWidth-1:0];
    end
  end

  // Pipeline control: hold every stage while the result is stalled
  assign advance     = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !advance;
  assign out_valid_o = valid_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[Stages-2:0], in_valid_i};
    end
  end

  // Stage datapath
  always_comb begin
    local_d = {2'b00, epoch_seconds_i}
              - {{(34-OffsetWidth){offset_q[OffsetWidth-1]}}, offset_q};
    t1_d    = local_d[33] ? '0 : local_d[32:0];

    prod1 = 63'(t1_q[32:2]) * 63'(RECIP_15_WIDE);
    prod2 = 53'(q2_q[27:2]) * 53'(RECIP_15_NARROW);
    prod3 = 37'(hrs3_q[20:3]) * 37'(RECIP_4383);

    blk_hours = 21'(blk4_q) * HOURS_PER_4YEARS;
    hrem_d    = 16'(hrs4_q - blk_hours);

    if (hrem5_q >= HOURS_YEAR_3) begin
      yoff_d = 2'd3;
      ysub_d = HOURS_YEAR_3;
    end else if (hrem5_q >= HOURS_YEAR_2) begin
      yoff_d = 2'd2;
      ysub_d = HOURS_YEAR_2;
    end else if (hrem5_q >= HOURS_YEAR_1) begin
      yoff_d = 2'd1;
      ysub_d = HOURS_YEAR_1;
    end else begin
      yoff_d = 2'd0;
      ysub_d = '0;
    end

    prod6 = 23'(hy6_q[13:3]) * 23'(RECIP_3);

    dayn  = dq7_q + 9'd1;
    leap7 = (yr7_q[1:0] == 2'b00);
    doy_d = (leap7 && dayn > LEAP_DAY_OF_YEAR) ? dayn - 9'd1 : dayn;
    ld_d  = leap7 && dayn == LEAP_DAY_OF_YEAR;

    mon_d = '0;
    for (int m = 1; m < 12; m++) begin
      if (doy8_q > month_base(4'(m))) begin
        mon_d = mon_d + 4'd1;
      end
    end
    day_d = 5'(doy8_q - month_base(mon_d));
    if (ld8_q) begin
      mon_d = MONTH_FEBRUARY;
      day_d = LEAP_DAY_OF_MONTH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      t1_q    <= t1_d;

      q2_q    <= prod1[62:RECIP_15_WIDE_SH];
      tl2_q   <= t1_q[5:0];

      hrs3_q  <= prod2[RECIP_15_NARROW_SH+20:RECIP_15_NARROW_SH];
      ml3_q   <= q2_q[5:0];
      sec3_q  <= tl2_q - 6'(q2_q[5:0] * 6'd60);

      blk4_q  <= prod3[RECIP_4383_SH+5:RECIP_4383_SH];
      hrs4_q  <= hrs3_q;
      min4_q  <= ml3_q - 6'(hrs3_q[5:0] * 6'd60);
      sec4_q  <= sec3_q;

      hrem5_q <= hrem_d;
      yb5_q   <= BASE_YEAR + {blk4_q, 2'b00};
      min5_q  <= min4_q;
      sec5_q  <= sec4_q;

      hy6_q   <= 14'(hrem5_q - ysub_d);
      yr6_q   <= yb5_q + 8'(yoff_d);
      min6_q  <= min5_q;
      sec6_q  <= sec5_q;

      dq7_q   <= prod6[RECIP_3_SH+8:RECIP_3_SH];
      hl7_q   <= hy6_q[4:0];
      yr7_q   <= yr6_q;
      min7_q  <= min6_q;
      sec7_q  <= sec6_q;

      doy8_q  <= doy_d;
      ld8_q   <= ld_d;
      hour8_q <= hl7_q - 5'(dq7_q[4:0] * 5'd24);
      yr8_q   <= yr7_q;
      min8_q  <= min7_q;
      sec8_q  <= sec7_q;

      sec9_q  <= sec8_q;
      min9_q  <= min8_q;
      hour9_q <= hour8_q;
      day9_q  <= day_d;
      mon9_q  <= mon_d;
      yr9_q   <= yr8_q;
    end
  end

  assign second_of_minute_o = sec9_q;
  assign minute_of_hour_o   = min9_q;
  assign hour_of_day_o      = hour9_q;
  assign day_of_month_o     = day9_q;
  assign month_index_o      = mon9_q;
  assign year_since_1900_o  = yr9_q;

`ifndef NO_ASSERTIONS
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> second_of_minute_o < 6'd60 && minute_of_hour_o < 6'd60
                    && hour_of_day_o < 5'd24)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> day_of_month_o >= 5'd1 && month_index_o <= 4'd11
                    && year_since_1900_o >= BASE_YEAR && year_since_1900_o <= 8'd209)
    else $error("calendar date out of range");

  a_leap_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && month_index_o == MONTH_FEBRUARY && day_of_month_o == LEAP_DAY_OF_MONTH
    |-> year_since_1900_o[1:0] == 2'b00)
    else $error("February 29 outside a leap year");
`endif

endmodule
